### src/lmfb_pkg.sv
// shared constants, codes and types of the led matrix frame buffer
package lmfb_pkg;

   localparam int ROWS      = 7;
   localparam int COLUMNS   = 21;
   localparam int DUMP_ROWS = (ROWS < 7) ? ROWS : 7;

   localparam int ROW_AW = $clog2(ROWS);
   localparam int COL_AW = $clog2(COLUMNS);
   localparam int PTR_W  = $clog2(DUMP_ROWS);

   localparam int KIND_W  = 4;
   localparam int COL_W   = 5;
   localparam int ROW_W   = 4;
   localparam int RW_W    = 5;
   localparam int RH_W    = 4;
   localparam int DIR_W   = 2;
   localparam int CNT_W   = 8;
   localparam int OP_W    = 2;
   localparam int DATA_W  = 21;
   localparam int LEVEL_W = 2;
   localparam int INDEX_W = 3;

   localparam logic [LEVEL_W-1:0] BRIGHT_MAX   = 2'd2;
   localparam logic [LEVEL_W-1:0] BRIGHT_RESET = 2'd2;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;
   localparam logic [DIR_W-1:0] FLIP_HORZ = 2'd0;
   localparam logic [DIR_W-1:0] FLIP_VERT = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET     = 4'd0,
      KIND_GET     = 4'd1,
      KIND_FILL    = 4'd2,
      KIND_RECT    = 4'd3,
      KIND_SHIFT   = 4'd4,
      KIND_FLIP    = 4'd5,
      KIND_INVERT  = 4'd6,
      KIND_COMBINE = 4'd7,
      KIND_DUMP    = 4'd8
   } lmfb_kind_type;

   typedef enum logic [OP_W-1:0] {
      OP_OR   = 2'd0,
      OP_AND  = 2'd1,
      OP_XOR  = 2'd2,
      OP_LOAD = 2'd3
   } lmfb_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_VSHIFT,
      ST_GET,
      ST_DUMP
   } lmfb_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [RW_W-1:0]   rect_width;
      logic [RH_W-1:0]   rect_height;
      logic              pixel_on;
      logic [DIR_W-1:0]  direction;
      logic [CNT_W-1:0]  shift_count;
      logic [OP_W-1:0]   combine_op;
      logic [DATA_W-1:0] row_data;
   } lmfb_item_type;

   typedef struct packed {
      logic capture;   // latch the accepted transaction
      logic apply;     // one-cycle frame update for the latched command
      logic vstep;     // move the frame one row up or down
      logic emit_get;  // load the get result into the output register
      logic emit_row;  // load the next dumped row into the output register
   } lmfb_cmd_type;

   typedef struct packed {
      lmfb_kind_type kind;
      logic          vertical;
      logic          steps_left;
      logic          out_free;
      logic          ptr_last;
   } lmfb_status_type;

endpackage

### src/lmfb_if.sv
// request and response channel interfaces of the led matrix frame buffer
interface lmfb_req_if;
   import lmfb_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [COL_W-1:0]  col;
   logic [ROW_W-1:0]  row;
   logic [RW_W-1:0]   rect_width;
   logic [RH_W-1:0]   rect_height;
   logic              pixel_on;
   logic [DIR_W-1:0]  direction;
   logic [CNT_W-1:0]  shift_count;
   logic [OP_W-1:0]   combine_op;
   logic [DATA_W-1:0] row_data;

   modport source (
      output valid, kind, col, row, rect_width, rect_height, pixel_on,
             direction, shift_count, combine_op, row_data,
      input  ready
   );

   modport sink (
      input  valid, kind, col, row, rect_width, rect_height, pixel_on,
             direction, shift_count, combine_op, row_data,
      output ready
   );
endinterface

interface lmfb_rsp_if;
   import lmfb_pkg::*;

   logic               valid;
   logic               ready;
   logic               pixel;
   logic [INDEX_W-1:0] row_index;
   logic [DATA_W-1:0]  row_bits;
   logic [LEVEL_W-1:0] level;
   logic               last;

   modport source (
      output valid, pixel, row_index, row_bits, level, last,
      input  ready
   );

   modport sink (
      input  valid, pixel, row_index, row_bits, level, last,
      output ready
   );
endinterface

### src/led_matrix_frame_buffer.sv
// top level of the 21x7 monochrome led matrix frame buffer
//
// usage
// - req_ch carries one command transaction (set, get, fill, rect, shift,
//   flip, invert, combine row, dump); it is taken when valid and ready are high
// - rsp_ch carries results: one for get, seven for dump (rows 0 to 6, active
//   low, brightness attached, last on row 6); other commands give none
// - csr_write_enable/csr_write_data write the brightness (values above 2 read as 2)
// sequencing
// - a command is accepted, then executed in the frame registers
// - a vertical shift by n below 7 then makes n row moves, one row move per cycle
// - get: result registered in the get state once the output register is free
// - dump: one row per cycle from the single frame read port while the output is free
// reset
// - synchronous; clears the frame to all pixels off, brightness to 2
// stalls
// - the output register holds a result while rsp_ch.ready is low; a next
//   command is still accepted, only further results wait
module led_matrix_frame_buffer (
   input  logic                         clock,
   input  logic                         reset,
   lmfb_req_if.sink                     req_ch,
   lmfb_rsp_if.source                   rsp_ch,
   input  logic                         csr_write_enable,
   input  logic [lmfb_pkg::LEVEL_W-1:0] csr_write_data
);
   import lmfb_pkg::*;

   lmfb_item_type   req_item;
   lmfb_cmd_type    cmd;
   lmfb_status_type status;

   // request payload gathered into one item
   assign req_item.kind        = req_ch.kind;
   assign req_item.col         = req_ch.col;
   assign req_item.row         = req_ch.row;
   assign req_item.rect_width  = req_ch.rect_width;
   assign req_item.rect_height = req_ch.rect_height;
   assign req_item.pixel_on    = req_ch.pixel_on;
   assign req_item.direction   = req_ch.direction;
   assign req_item.shift_count = req_ch.shift_count;
   assign req_item.combine_op  = req_ch.combine_op;
   assign req_item.row_data    = req_ch.row_data;

   // sequencer: one command at a time
   lmfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame registers, brightness and output register
   lmfb_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_item         (req_item),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_pixel        (rsp_ch.pixel),
      .rsp_row_index    (rsp_ch.row_index),
      .rsp_row_bits     (rsp_ch.row_bits),
      .rsp_level        (rsp_ch.level),
      .rsp_last         (rsp_ch.last)
   );

endmodule

### src/lmfb_ctrl.sv
// command sequencer of the led matrix frame buffer
module lmfb_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lmfb_pkg::lmfb_status_type status,
   output lmfb_pkg::lmfb_cmd_type    cmd
);
   import lmfb_pkg::*;

   lmfb_state_type state_ff;
   lmfb_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.apply = 1'b1;
            case (status.kind)
               KIND_GET:   state_in = ST_GET;
               KIND_DUMP:  state_in = ST_DUMP;
               KIND_SHIFT: state_in = status.vertical ? ST_VSHIFT : ST_IDLE;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_VSHIFT: begin
            if (status.steps_left) begin
               cmd.vstep = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GET: begin
            if (status.out_free) begin
               cmd.emit_get = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (status.out_free) begin
               cmd.emit_row = 1'b1;
               if (status.ptr_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction not executed next cycle");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.apply, cmd.vstep, cmd.emit_get, cmd.emit_row}))
      else $error("more than one datapath command at once");

   a_vshift_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VSHIFT && !status.steps_left) |=> (state_ff == ST_IDLE))
      else $error("vertical shift did not finish");
`endif

endmodule

### src/lmfb_dpath.sv
// frame storage, command execution and output register of the led matrix frame buffer
module lmfb_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  lmfb_pkg::lmfb_item_type        req_item,
   input  lmfb_pkg::lmfb_cmd_type         cmd,
   output lmfb_pkg::lmfb_status_type      status,
   input  logic                           csr_write_enable,
   input  logic [lmfb_pkg::LEVEL_W-1:0]   csr_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_pixel,
   output logic [lmfb_pkg::INDEX_W-1:0]   rsp_row_index,
   output logic [lmfb_pkg::DATA_W-1:0]    rsp_row_bits,
   output logic [lmfb_pkg::LEVEL_W-1:0]   rsp_level,
   output logic                           rsp_last
);
   import lmfb_pkg::*;

   logic [COLUMNS-1:0] frame_ff [ROWS];
   logic [COLUMNS-1:0] frame_in [ROWS];
   lmfb_item_type      item_ff;
   logic [ROW_AW-1:0]  steps_ff;
   logic [ROW_AW-1:0]  steps_in;
   logic [PTR_W-1:0]   ptr_ff;
   logic [LEVEL_W-1:0] bright_ff;

   logic               rsp_valid_ff;
   logic               pixel_ff;
   logic [INDEX_W-1:0] row_index_ff;
   logic [DATA_W-1:0]  row_bits_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               last_ff;

   logic               row_ok;
   logic               in_frame;
   logic [ROW_AW-1:0]  row_idx;
   logic [ROW_AW-1:0]  rd_addr;
   logic [COLUMNS-1:0] rd_data;
   logic [COLUMNS-1:0] data_row;
   logic [COLUMNS-1:0] rect_mask;
   logic [RW_W:0]      col_end;
   logic [RH_W:0]      row_end;
   logic               out_free;
   logic               ptr_last;

   assign row_ok   = item_ff.row < ROW_W'(ROWS);
   assign in_frame = row_ok && (item_ff.col < COL_W'(COLUMNS));
   assign row_idx  = item_ff.row[ROW_AW-1:0];
   assign rd_addr  = cmd.emit_row ? ROW_AW'(ptr_ff) : row_idx;
   assign rd_data  = frame_ff[rd_addr];
   assign data_row = item_ff.row_data[COLUMNS-1:0];
   assign col_end  = {1'b0, item_ff.col} + {1'b0, item_ff.rect_width};
   assign row_end  = {1'b0, item_ff.row} + {1'b0, item_ff.rect_height};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ptr_last = ptr_ff == PTR_W'(DUMP_ROWS - 1);

   always_comb begin
      for (int x = 0; x < COLUMNS; x++) begin
         rect_mask[x] = (COL_W'(x) >= item_ff.col) && ((RW_W + 1)'(x) < col_end);
      end
   end

   // frame next state
   always_comb begin
      steps_in = steps_ff;
      for (int y = 0; y < ROWS; y++) begin
         frame_in[y] = frame_ff[y];
      end
      if (cmd.apply) begin
         case (lmfb_kind_type'(item_ff.kind))
            KIND_SET: begin
               if (in_frame) begin
                  frame_in[row_idx][item_ff.col[COL_AW-1:0]] = item_ff.pixel_on;
               end
            end
            KIND_FILL: begin
               for (int y = 0; y < ROWS; y++) begin
                  frame_in[y] = item_ff.pixel_on ? '1 : '0;
               end
            end
            KIND_RECT: begin
               if (in_frame) begin
                  for (int y = 0; y < ROWS; y++) begin
                     if ((ROW_W'(y) >= item_ff.row) && ((RH_W + 1)'(y) < row_end)) begin
                        frame_in[y] = item_ff.pixel_on ? (frame_ff[y] | rect_mask)
                                                       : (frame_ff[y] & ~rect_mask);
                     end
                  end
               end
            end
            KIND_SHIFT: begin
               if (item_ff.direction == DIR_UP || item_ff.direction == DIR_DOWN) begin
                  if (item_ff.shift_count >= CNT_W'(ROWS)) begin
                     steps_in = '0;
                     for (int y = 0; y < ROWS; y++) begin
                        frame_in[y] = '0;
                     end
                  end else begin
                     steps_in = item_ff.shift_count[ROW_AW-1:0];
                  end
               end else if (item_ff.shift_count >= CNT_W'(COLUMNS)) begin
                  for (int y = 0; y < ROWS; y++) begin
                     frame_in[y] = '0;
                  end
               end else begin
                  for (int y = 0; y < ROWS; y++) begin
                     frame_in[y] = (item_ff.direction == DIR_LEFT)
                                   ? (frame_ff[y] >> item_ff.shift_count)
                                   : (frame_ff[y] << item_ff.shift_count);
                  end
               end
            end
            KIND_FLIP: begin
               if (item_ff.direction == FLIP_HORZ) begin
                  for (int y = 0; y < ROWS; y++) begin
                     for (int x = 0; x < COLUMNS; x++) begin
                        frame_in[y][x] = frame_ff[y][COLUMNS - 1 - x];
                     end
                  end
               end else if (item_ff.direction == FLIP_VERT) begin
                  for (int y = 0; y < ROWS; y++) begin
                     frame_in[y] = frame_ff[ROWS - 1 - y];
                  end
               end
            end
            KIND_INVERT: begin
               for (int y = 0; y < ROWS; y++) begin
                  frame_in[y] = ~frame_ff[y];
               end
            end
            KIND_COMBINE: begin
               if (row_ok) begin
                  case (lmfb_op_type'(item_ff.combine_op))
                     OP_OR:   frame_in[row_idx] = rd_data | data_row;
                     OP_AND:  frame_in[row_idx] = rd_data & data_row;
                     OP_XOR:  frame_in[row_idx] = rd_data ^ data_row;
                     OP_LOAD: frame_in[row_idx] = data_row;
                     default: frame_in[row_idx] = rd_data;
                  endcase
               end
            end
            default: ;
         endcase
      end else if (cmd.vstep) begin
         steps_in = steps_ff - 1'b1;
         for (int y = 0; y < ROWS; y++) begin
            if (item_ff.direction == DIR_UP) begin
               frame_in[y] = (y < ROWS - 1) ? frame_ff[(y + 1) % ROWS] : '0;
            end else begin
               frame_in[y] = (y > 0) ? frame_ff[(y + ROWS - 1) % ROWS] : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int y = 0; y < ROWS; y++) begin
            frame_ff[y] <= '0;
         end
         steps_ff  <= '0;
         ptr_ff    <= '0;
         bright_ff <= BRIGHT_RESET;
      end else begin
         for (int y = 0; y < ROWS; y++) begin
            frame_ff[y] <= frame_in[y];
         end
         steps_ff <= steps_in;
         if (cmd.capture) begin
            ptr_ff <= '0;
         end else if (cmd.emit_row) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         if (csr_write_enable) begin
            bright_ff <= (csr_write_data > BRIGHT_MAX) ? BRIGHT_MAX : csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_get || cmd.emit_row) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_get) begin
         pixel_ff     <= in_frame ? rd_data[item_ff.col[COL_AW-1:0]] : 1'b0;
         row_index_ff <= '0;
         row_bits_ff  <= '0;
         level_ff     <= '0;
         last_ff      <= 1'b1;
      end else if (cmd.emit_row) begin
         pixel_ff     <= 1'b0;
         row_index_ff <= INDEX_W'(ptr_ff);
         row_bits_ff  <= DATA_W'(~rd_data);
         level_ff     <= bright_ff;
         last_ff      <= ptr_last;
      end
   end

   assign status.kind       = lmfb_kind_type'(item_ff.kind);
   assign status.vertical   = (item_ff.direction == DIR_UP) || (item_ff.direction == DIR_DOWN);
   assign status.steps_left = steps_ff != '0;
   assign status.out_free   = out_free;
   assign status.ptr_last   = ptr_last;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = pixel_ff;
   assign rsp_row_index = row_index_ff;
   assign rsp_row_bits  = row_bits_ff;
   assign rsp_level     = level_ff;
   assign rsp_last      = last_ff;

`ifndef SYNTHESIS
   a_bright_range: assert property (@(posedge clock) disable iff (reset)
      bright_ff <= BRIGHT_MAX)
      else $error("brightness register above its maximum");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_get || cmd.emit_row) |-> out_free)
      else $error("output register overwritten before transaction");

   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_row && ptr_last) |=> (rsp_valid_ff && last_ff))
      else $error("final dumped row not flagged last");

   a_vstep_count: assert property (@(posedge clock) disable iff (reset)
      cmd.vstep |-> (steps_ff != '0))
      else $error("vertical step with no steps left");
`endif

endmodule
